/* hdl/cnv_pkg.sv */
package cnv_pkg;

	localparam int PIX_W       = 8;
	localparam int ACC_W       = 16;
	localparam int COORD_W     = 6;
	localparam int NUM_FILTERS = 4;
	localparam int NUM_TAPS    = 9;
	localparam int NUM_REGS    = 5;
	localparam int REG_W       = 64;
	localparam int REG_IDX_W   = 3;
	localparam int BIAS_BASE   = 36;
	localparam int BIAS_SHIFT  = 4;
	localparam int OUT_SHIFT   = 7;

	localparam logic [REG_IDX_W-1:0] REG_WEIGHT_A = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_WEIGHT_B = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_WEIGHT_C = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_WEIGHT_D = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_WEIGHT_E = 3'd4;

	typedef logic [PIX_W-1:0] pixel_t;
	typedef pixel_t [NUM_TAPS-1:0] window_t;
	typedef logic [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic   has_result;
		logic   frame_end;
		coord_t row;
		coord_t col;
	} win_info_t;

endpackage

/* hdl/cnv_ram.sv */
module cnv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 42
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/cnv_window.sv */
module cnv_window #(
	parameter int IMAGE_WIDTH  = 42,
	parameter int IMAGE_HEIGHT = 42
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  cnv_pkg::pixel_t    pixel,
	output cnv_pkg::window_t   window,
	output cnv_pkg::win_info_t info
);

	import cnv_pkg::*;

	localparam int CW = $clog2(IMAGE_WIDTH);
	localparam int RW = $clog2(IMAGE_HEIGHT);

	logic [CW-1:0] col_q;
	logic [CW-1:0] col_next;
	logic [CW-1:0] raddr;
	logic [RW-1:0] row_q;
	logic [RW-1:0] row_next;
	logic          col_last;
	logic          row_last;
	logic [2*PIX_W-1:0] line_rdata;
	pixel_t        top;
	pixel_t        mid;
	pixel_t        win_q [6];

	assign col_last = (col_q == CW'(IMAGE_WIDTH - 1));
	assign row_last = (row_q == RW'(IMAGE_HEIGHT - 1));
	assign col_next = col_last ? '0 : col_q + CW'(1);
	assign row_next = col_last ? (row_last ? '0 : row_q + RW'(1)) : row_q;
	assign raddr    = accept ? col_next : col_q;

	// upper line in the high byte, lower line in the low byte
	cnv_ram #(
		.WIDTH(2 * PIX_W),
		.DEPTH(IMAGE_WIDTH)
	) u_lines (
		.clk  (clk),
		.we   (accept),
		.waddr(col_q),
		.wdata({mid, pixel}),
		.raddr(raddr),
		.rdata(line_rdata)
	);

	assign top = line_rdata[2*PIX_W-1:PIX_W];
	assign mid = line_rdata[PIX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (accept) begin
			col_q    <= col_next;
			row_q    <= row_next;
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= pixel;
		end
	end

	assign window[0] = win_q[0];
	assign window[1] = win_q[3];
	assign window[2] = top;
	assign window[3] = win_q[1];
	assign window[4] = win_q[4];
	assign window[5] = mid;
	assign window[6] = win_q[2];
	assign window[7] = win_q[5];
	assign window[8] = pixel;

	assign info.has_result = (row_q >= RW'(2)) && (col_q >= CW'(2));
	assign info.frame_end  = row_last && col_last;
	assign info.row        = COORD_W'(row_q) - COORD_W'(2);
	assign info.col        = COORD_W'(col_q) - COORD_W'(2);

endmodule

/* hdl/cnv_filter.sv */
module cnv_filter (
	input  cnv_pkg::window_t window,
	input  cnv_pkg::window_t weights,
	input  cnv_pkg::pixel_t  bias,
	output cnv_pkg::pixel_t  chan
);

	import cnv_pkg::*;

	logic signed [ACC_W-1:0] prod [NUM_TAPS];
	logic        [ACC_W-1:0] bias_term;
	logic        [ACC_W-1:0] s01, s23, s45, s67, s8b;
	logic        [ACC_W-1:0] s03, s47, s07, total;

	always_comb begin
		for (int t = 0; t < NUM_TAPS; t++) begin
			prod[t] = ACC_W'($signed(window[t])) * ACC_W'($signed(weights[t]));
		end
	end

	assign bias_term = {{(ACC_W - PIX_W - BIAS_SHIFT){bias[PIX_W-1]}}, bias,
		{BIAS_SHIFT{1'b0}}};

	// adder tree, all sums wrap at the accumulator width
	assign s01   = prod[0] + prod[1];
	assign s23   = prod[2] + prod[3];
	assign s45   = prod[4] + prod[5];
	assign s67   = prod[6] + prod[7];
	assign s8b   = prod[8] + bias_term;
	assign s03   = s01 + s23;
	assign s47   = s45 + s67;
	assign s07   = s03 + s47;
	assign total = s07 + s8b;

	// shift and relu
	assign chan = total[ACC_W-1] ? '0 : total[OUT_SHIFT+PIX_W-1:OUT_SHIFT];

endmodule

/* hdl/conv3x3_relu_int8_four_filter_unit.sv */
// results pass the window register, then the output register; out_stall holds both
// throughput: one pixel per cycle unless in_stall; a window's four filters are computed
// combinationally by 36 parallel 8x8 multipliers between the window and output registers
// reset clears weight registers, counters, window shift registers and all valid flags;
// the line store is not cleared, it is always written before it is read for a result
module conv3x3_relu_int8_four_filter_unit #(
	parameter int IMAGE_WIDTH  = 42,
	parameter int IMAGE_HEIGHT = 42
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [cnv_pkg::REG_IDX_W-1:0]        wr_index,
	input  logic [cnv_pkg::REG_W-1:0]            wr_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [cnv_pkg::PIX_W-1:0]     pixel,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [cnv_pkg::COORD_W-1:0]          out_row,
	output logic [cnv_pkg::COORD_W-1:0]          out_col,
	output logic [cnv_pkg::PIX_W-1:0]            chan0,
	output logic [cnv_pkg::PIX_W-1:0]            chan1,
	output logic [cnv_pkg::PIX_W-1:0]            chan2,
	output logic [cnv_pkg::PIX_W-1:0]            chan3,
	output logic                                 frame_end
);

	import cnv_pkg::*;

	logic [REG_W-1:0]           weight_q [NUM_REGS];
	logic [NUM_REGS*REG_W-1:0]  weight_flat;
	window_t                    window;
	win_info_t                  info;
	logic                       accept;
	logic                       out_free;
	logic                       s1_free;
	logic                       valid_s1;
	window_t                    window_s1;
	coord_t                     row_s1;
	coord_t                     col_s1;
	logic                       frame_end_s1;
	window_t                    tap_w [NUM_FILTERS];
	pixel_t                     bias  [NUM_FILTERS];
	pixel_t                     chan  [NUM_FILTERS];
	logic                       valid_s2;
	coord_t                     row_s2;
	coord_t                     col_s2;
	pixel_t                     chan_s2 [NUM_FILTERS];
	logic                       frame_end_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				weight_q[i] <= '0;
			end
		end else if (wr_en) begin
			if (wr_index == REG_WEIGHT_A || wr_index == REG_WEIGHT_B ||
				wr_index == REG_WEIGHT_C || wr_index == REG_WEIGHT_D ||
				wr_index == REG_WEIGHT_E) begin
				weight_q[wr_index] <= wr_data;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_REGS; i++) begin
			weight_flat[i*REG_W +: REG_W] = weight_q[i];
		end
	end

	for (genvar f = 0; f < NUM_FILTERS; f++) begin : g_weights
		for (genvar t = 0; t < NUM_TAPS; t++) begin : g_tap
			assign tap_w[f][t] = weight_flat[PIX_W*(NUM_FILTERS*t + f) +: PIX_W];
		end
		assign bias[f] = weight_flat[PIX_W*(BIAS_BASE + f) +: PIX_W];
	end

	assign out_free = !valid_s2 || !out_stall;
	assign s1_free  = !valid_s1 || out_free;
	assign in_stall = !s1_free;
	assign accept   = in_valid && s1_free;

	cnv_window #(
		.IMAGE_WIDTH (IMAGE_WIDTH),
		.IMAGE_HEIGHT(IMAGE_HEIGHT)
	) u_window (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.pixel (pixel_t'(pixel)),
		.window(window),
		.info  (info)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= info.has_result;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && info.has_result) begin
			window_s1    <= window;
			row_s1       <= info.row;
			col_s1       <= info.col;
			frame_end_s1 <= info.frame_end;
		end
	end

	for (genvar f = 0; f < NUM_FILTERS; f++) begin : g_filter
		cnv_filter u_filter (
			.window (window_s1),
			.weights(tap_w[f]),
			.bias   (bias[f]),
			.chan   (chan[f])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			row_s2       <= row_s1;
			col_s2       <= col_s1;
			frame_end_s2 <= frame_end_s1;
			for (int f = 0; f < NUM_FILTERS; f++) begin
				chan_s2[f] <= chan[f];
			end
		end
	end

	assign out_valid = valid_s2;
	assign out_row   = row_s2;
	assign out_col   = col_s2;
	assign chan0     = chan_s2[0];
	assign chan1     = chan_s2[1];
	assign chan2     = chan_s2[2];
	assign chan3     = chan_s2[3];
	assign frame_end = frame_end_s2;

endmodule

/* tb/conv_window_checker.sv */
module conv_window_checker #(
	parameter int IMAGE_WIDTH  = 42,
	parameter int IMAGE_HEIGHT = 42
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [cnv_pkg::REG_IDX_W-1:0]        wr_index,
	input  logic [cnv_pkg::REG_W-1:0]            wr_data,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic signed [cnv_pkg::PIX_W-1:0]     pixel,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic [cnv_pkg::COORD_W-1:0]          out_row,
	input  logic [cnv_pkg::COORD_W-1:0]          out_col,
	input  logic [cnv_pkg::PIX_W-1:0]            chan0,
	input  logic [cnv_pkg::PIX_W-1:0]            chan1,
	input  logic [cnv_pkg::PIX_W-1:0]            chan2,
	input  logic [cnv_pkg::PIX_W-1:0]            chan3,
	input  logic                                 frame_end,
	output int                                   mismatches,
	output int                                   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import cnv_pkg::*;

	typedef struct packed {
		coord_t                                row;
		coord_t                                col;
		logic [NUM_FILTERS-1:0][PIX_W-1:0]     chan;
		logic                                  frame_end;
	} window_result_t;

	logic [REG_W-1:0] weight_regs [NUM_REGS];
	pixel_t           upper_line [IMAGE_WIDTH];
	pixel_t           lower_line [IMAGE_WIDTH];
	pixel_t           prev_cols [6];
	int               row_cnt;
	int               col_cnt;
	window_result_t   expected_windows [$];
	window_result_t   want;
	logic [NUM_FILTERS-1:0][PIX_W-1:0] got_chan;

	function automatic logic signed [PIX_W-1:0] tap_weight(int k);
		return weight_regs[k / 8][8 * (k % 8) +: 8];
	endfunction

	function automatic logic [PIX_W-1:0] filter_output(window_t win, int f);
		logic [ACC_W-1:0]        acc;
		logic signed [ACC_W-1:0] prod;
		logic signed [PIX_W-1:0] w;
		logic signed [PIX_W-1:0] b;
		acc = '0;
		for (int t = 0; t < NUM_TAPS; t++) begin
			w = tap_weight(4 * t + f);
			prod = $signed(win[t]) * w;
			acc = acc + prod;
		end
		b = tap_weight(BIAS_BASE + f);
		acc = acc + {{4{b[7]}}, b, 4'b0000};
		if ($signed(acc) < (1 << OUT_SHIFT))
			return '0;
		return acc[OUT_SHIFT +: PIX_W];
	endfunction

	task automatic shift_in_pixel(input pixel_t bot);
		pixel_t         top_px;
		pixel_t         mid_px;
		window_t        win;
		window_result_t res;
		top_px = upper_line[col_cnt];
		mid_px = lower_line[col_cnt];
		win[0] = prev_cols[0]; win[1] = prev_cols[3]; win[2] = top_px;
		win[3] = prev_cols[1]; win[4] = prev_cols[4]; win[5] = mid_px;
		win[6] = prev_cols[2]; win[7] = prev_cols[5]; win[8] = bot;
		if (row_cnt >= 2 && col_cnt >= 2) begin
			res.row = coord_t'(row_cnt - 2);
			res.col = coord_t'(col_cnt - 2);
			for (int f = 0; f < NUM_FILTERS; f++)
				res.chan[f] = filter_output(win, f);
			res.frame_end = (row_cnt == IMAGE_HEIGHT - 1) && (col_cnt == IMAGE_WIDTH - 1);
			expected_windows.push_back(res);
		end
		prev_cols[0] = prev_cols[3];
		prev_cols[1] = prev_cols[4];
		prev_cols[2] = prev_cols[5];
		prev_cols[3] = top_px;
		prev_cols[4] = mid_px;
		prev_cols[5] = bot;
		upper_line[col_cnt] = mid_px;
		lower_line[col_cnt] = bot;
		col_cnt++;
		if (col_cnt >= IMAGE_WIDTH) begin
			col_cnt = 0;
			row_cnt++;
			if (row_cnt >= IMAGE_HEIGHT)
				row_cnt = 0;
		end
	endtask

	task automatic report_field(string field, int expected, int actual);
		if (expected != actual) begin
			$display("%0t: %s expected %0d actual %0d", $time, field, expected, actual);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (weight_regs[i])
				weight_regs[i] = '0;
			foreach (upper_line[i]) begin
				upper_line[i] = '0;
				lower_line[i] = '0;
			end
			foreach (prev_cols[i])
				prev_cols[i] = '0;
			row_cnt = 0;
			col_cnt = 0;
			expected_windows.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (wr_en && wr_index < NUM_REGS)
				weight_regs[wr_index] = wr_data;
			if (in_valid && !in_stall)
				shift_in_pixel(pixel);
			if (out_valid && !out_stall) begin
				if (expected_windows.size() == 0) begin
					$display("%0t: unexpected result expected none actual row %0d col %0d",
						$time, out_row, out_col);
					mismatches++;
				end else begin
					want = expected_windows.pop_front();
					got_chan = {chan3, chan2, chan1, chan0};
					report_field("out_row", want.row, out_row);
					report_field("out_col", want.col, out_col);
					for (int f = 0; f < NUM_FILTERS; f++)
						report_field($sformatf("chan%0d", f), want.chan[f], got_chan[f]);
					report_field("frame_end", want.frame_end, frame_end);
				end
			end
			outstanding = expected_windows.size();
		end
	end

endmodule

/* tb/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import cnv_pkg::*;

	localparam int IMAGE_WIDTH   = 42;
	localparam int IMAGE_HEIGHT  = 42;
	localparam int TOTAL_PIXELS  = 1650;
	localparam int PHASE_PIXELS  = 200;
	localparam int SETTLE_CYCLES = 4;
	localparam int LONG_HOLD     = 300;
	localparam int MAX_CYCLES    = 200000;

	localparam logic [REG_IDX_W-1:0] WEIGHT_REGS [NUM_REGS] = '{
		REG_WEIGHT_A, REG_WEIGHT_B, REG_WEIGHT_C, REG_WEIGHT_D, REG_WEIGHT_E
	};

	localparam logic [PIX_W-1:0] DIRECTED_PIXELS [25] = '{
		8'h80, 8'h7f, 8'h00, 8'hff, 8'h01, 8'h80, 8'h80, 8'h7f, 8'h7f, 8'h55,
		8'haa, 8'h00, 8'hff, 8'h80, 8'h7f, 8'h01, 8'hfe, 8'h40, 8'hc0, 8'h80,
		8'h7f, 8'h0f, 8'hf0, 8'h80, 8'h7f
	};

	typedef enum int {W_RANDOM, W_MAX, W_MIN, W_EXTREMES, W_SMALL} weight_mode_t;
	typedef enum int {P_RANDOM, P_EXTREMES, P_SMALL} pixel_mode_t;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    wr_en     = 1'b0;
	logic [REG_IDX_W-1:0]    wr_index  = '0;
	logic [REG_W-1:0]        wr_data   = '0;
	logic                    in_valid  = 1'b0;
	logic signed [PIX_W-1:0] pixel     = '0;
	logic                    out_stall = 1'b0;
	logic                    in_stall;
	logic                    out_valid;
	logic [COORD_W-1:0]      out_row;
	logic [COORD_W-1:0]      out_col;
	logic [PIX_W-1:0]        chan0;
	logic [PIX_W-1:0]        chan1;
	logic [PIX_W-1:0]        chan2;
	logic [PIX_W-1:0]        chan3;
	logic                    frame_end;

	int mismatches;
	int outstanding;
	int cycles          = 0;
	int pixels_sent     = 0;
	bit sender_steady   = 1'b0;
	bit receiver_steady = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	conv3x3_relu_int8_four_filter_unit #(
		.IMAGE_WIDTH(IMAGE_WIDTH),
		.IMAGE_HEIGHT(IMAGE_HEIGHT)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .pixel(pixel),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_row(out_row), .out_col(out_col),
		.chan0(chan0), .chan1(chan1), .chan2(chan2), .chan3(chan3),
		.frame_end(frame_end)
	);

	conv_window_checker #(
		.IMAGE_WIDTH(IMAGE_WIDTH),
		.IMAGE_HEIGHT(IMAGE_HEIGHT)
	) checker_i (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .pixel(pixel),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_row(out_row), .out_col(out_col),
		.chan0(chan0), .chan1(chan1), .chan2(chan2), .chan3(chan3),
		.frame_end(frame_end),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == MAX_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic [PIX_W-1:0] extreme_byte();
		case ($urandom_range(0, 4))
			0: return 8'h80;
			1: return 8'h7f;
			2: return 8'h00;
			3: return 8'hff;
			default: return 8'h01;
		endcase
	endfunction

	function automatic logic [REG_W-1:0] draw_weights(weight_mode_t mode);
		logic [REG_W-1:0] v;
		for (int i = 0; i < REG_W / 8; i++) begin
			case (mode)
				W_MAX:      v[8*i +: 8] = 8'h7f;
				W_MIN:      v[8*i +: 8] = 8'h80;
				W_EXTREMES: v[8*i +: 8] = extreme_byte();
				W_SMALL:    v[8*i +: 8] = 8'($urandom_range(0, 31)) - 8'd16;
				default:    v[8*i +: 8] = 8'($urandom);
			endcase
		end
		return v;
	endfunction

	function automatic logic [PIX_W-1:0] draw_pixel(pixel_mode_t mode);
		case (mode)
			P_EXTREMES: return extreme_byte();
			P_SMALL:    return 8'($urandom_range(0, 31)) - 8'd16;
			default:    return 8'($urandom);
		endcase
	endfunction

	task automatic send_pixel(input logic [PIX_W-1:0] value);
		int gap;
		if ($urandom_range(0, 29) == 0)
			sender_steady = !sender_steady;
		gap = sender_steady ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel <= value;
		do @(posedge clk); while (in_stall);
		pixels_sent++;
	endtask

	// stop offering, wait for every outstanding window, let the pipeline settle
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_weights(weight_mode_t mode);
		foreach (WEIGHT_REGS[r]) begin
			wr_en <= 1'b1;
			wr_index <= WEIGHT_REGS[r];
			wr_data <= draw_weights(mode);
			@(posedge clk);
		end
		// index past the last register must be ignored
		wr_index <= REG_IDX_W'(NUM_REGS + $urandom_range(0, 2));
		wr_data <= {$urandom, $urandom};
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	initial begin
		int hold;
		int taken;
		taken = 0;
		forever begin
			if ($urandom_range(0, 29) == 0)
				receiver_steady = !receiver_steady;
			if (taken == 400 || taken == 1200)
				hold = LONG_HOLD;
			else
				hold = receiver_steady ? 0 : $urandom_range(0, 10);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	initial begin
		int           phase;
		weight_mode_t wmode;
		pixel_mode_t  pmode;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED_PIXELS[i])
			send_pixel(DIRECTED_PIXELS[i]);
		phase = 0;
		while (pixels_sent < TOTAL_PIXELS) begin
			drain();
			wmode = (phase < 5) ? weight_mode_t'(phase) : weight_mode_t'($urandom_range(0, 4));
			if (phase == 1 || phase == 2)
				pmode = P_EXTREMES;
			else if ($urandom_range(0, 3) != 0)
				pmode = P_RANDOM;
			else
				pmode = pixel_mode_t'($urandom_range(0, 2));
			load_weights(wmode);
			for (int i = 0; i < PHASE_PIXELS && pixels_sent < TOTAL_PIXELS; i++)
				send_pixel(draw_pixel(pmode));
			phase++;
		end
		drain();
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* files.f */
hdl/cnv_pkg.sv
hdl/cnv_ram.sv
hdl/cnv_window.sv
hdl/cnv_filter.sv
hdl/conv3x3_relu_int8_four_filter_unit.sv
tb/conv_window_checker.sv
tb/testbench.sv
